// ===== rtl/rk4sb_pkg.sv =====
`timescale 1ns / 1ps
package rk4sb_pkg;

  // number format and sizing
  localparam int FRAC_BITS      = 24;
  localparam int MAX_POINTS     = 64;
  localparam int MAX_ITERATIONS = 16;
  localparam int STEP_W         = $clog2(MAX_POINTS);
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

  typedef logic signed [31:0] q_t;

  // fixed-point constants
  localparam logic signed [31:0] Q_ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] Q_TWO   = 32'sd2 <<< FRAC_BITS;
  localparam logic signed [31:0] Q_SLOPE2 =
    32'(((64'd8 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [63:0] SEC_CLAMP = 64'd1 << 40;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_POSITION = 2'd0,
    CFG_STEP_SIZE      = 2'd1,
    CFG_STEP_COUNT     = 2'd2,
    CFG_TOLERANCE      = 2'd3
  } cfg_index_t;

  // saturate a wide signed value to 32 bits
  function automatic q_t sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    else if (v < -48'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // halve, truncating toward zero
  function automatic q_t half32(input q_t v);
    logic signed [32:0] t;
    t = 33'(v) + $signed({32'd0, v[31]});
    return t[32:1];
  endfunction

endpackage

// ===== rtl/rk4sb_if.sv =====
`timescale 1ns / 1ps
interface rk4sb_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] start_value;
  logic signed [31:0] end_value;
  modport source(output valid, start_value, end_value, input ready);
  modport sink(input valid, start_value, end_value, output ready);
endinterface

interface rk4sb_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] position;
  logic signed [31:0] solution_value;
  logic converged;
  logic last_point;
  modport source(output valid, position, solution_value, converged, last_point, input ready);
  modport sink(input valid, position, solution_value, converged, last_point, output ready);
endinterface

// ===== rtl/rk4_shooting_boundary_solver.sv =====
`timescale 1ns / 1ps
// Shooting-method boundary solver for y'' = -4x*y' - (4x^2+2)*y, Q8.24.
// Input channel in_ch carries one word (start_value, end_value). The block
// integrates with RK4 from slopes 1.0 and 0.8, refines the slope by secant
// steps, then sends one word per grid point on out_ch (position,
// solution_value, converged, last_point), step_count+1 words in order of x.
// Configuration is written through cfg_we/cfg_index/cfg_data, by the user
// only while idle; the block itself does not enforce this. in_ch.ready is
// high only while idle; a word occupies the block until its last point has
// been handed to the output register.
// Each RK4 step makes 20 products on the shared multiplier and two
// shift-and-add divisions by 6. An item takes (3 + iterations) runs of
// step_count steps, and each secant update adds one wide product and a
// serial division.
// A stalled receiver holds the output register; the sequencer waits at
// each point until the register is free, no point is lost.
// Reset (synchronous, rst high) restores the register defaults and returns
// the sequencer to idle with no output word pending.
module rk4_shooting_boundary_solver import rk4sb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rk4sb_in_if.sink    in_ch,
  rk4sb_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_RUN, S_EMIT, S_STEP, S_MXZ, S_MXX, S_MQY, S_MHF, S_MHZ,
    S_NEXT, S_DIVK, S_DIVL, S_ADV, S_END, S_CHECK, S_SMUL, S_SDIV
  } state_t;

  typedef enum logic [1:0] {R_F1, R_F2, R_ITER, R_FINAL} run_t;

  // configuration registers
  q_t          start_position;
  logic [30:0] step_size;
  logic [5:0]  step_count;
  logic [30:0] tolerance;

  state_t state;
  run_t   rk;
  logic [1:0] ph;
  logic [1:0] sg;
  q_t y0, yt, nu1, nu2, f1, f2;
  q_t x, y, z, xm, xe, sx, sy, sz, tv, qv, fv;
  logic signed [35:0] ksum, lsum;
  logic signed [37:0] xacc;
  logic signed [63:0] sprod;
  logic [STEP_W-1:0] idx;
  logic [ITER_W-1:0] iter;
  logic conv;

  // output register
  logic ov, oconv, olast;
  q_t opos, oval;
  logic o_free;

  // shared units
  logic signed [32:0] ma, mb;
  logic signed [63:0] mp;
  q_t mr;
  logic dv_start, dv_busy, dv_done, dv_neg;
  logic signed [63:0] dv_num;
  logic signed [33:0] dv_den;
  logic [63:0] dv_mag;

  // divide by 6: halve, then a shift-add series for 1/3 and a remainder fix-up
  logic [3:0]         d6_cnt;
  logic               d6_neg;
  logic [33:0]        d6_m;
  logic [33:0]        d6_q;
  logic [35:0]        d6_r;
  logic signed [35:0] d6_sum;
  logic [35:0]        d6_abs;

  rk4sb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp), .r(mr));

  rk4sb_div u_div (
    .clk(clk), .rst(rst), .start(dv_start),
    .num(dv_num), .den(dv_den), .busy(dv_busy), .done(dv_done),
    .qmag(dv_mag), .qneg(dv_neg)
  );

  // derived values
  logic [STEP_W-1:0] n_steps;
  q_t h;
  logic w2;
  logic signed [35:0] q6;
  logic [32:0] f2mag;
  logic [40:0] cmag;
  logic signed [42:0] corr;

  assign n_steps = (step_count > 6'(MAX_POINTS - 1)) ? STEP_W'(MAX_POINTS - 1)
                                                      : STEP_W'(step_count);
  assign h      = {1'b0, step_size};
  assign w2     = (sg == 2'd1) || (sg == 2'd2);
  assign d6_sum = (state == S_DIVL) ? lsum : ksum;
  assign d6_abs = d6_sum[35] ? 36'(-d6_sum) : 36'(d6_sum);
  assign q6     = d6_neg ? -$signed({2'b0, d6_q}) : $signed({2'b0, d6_q});
  assign f2mag  = f2[31] ? 33'(-33'(f2)) : 33'(f2);
  assign cmag   = (dv_mag > SEC_CLAMP) ? SEC_CLAMP[40:0] : dv_mag[40:0];
  assign corr   = dv_neg ? -$signed({2'b0, cmag}) : $signed({2'b0, cmag});
  assign o_free = !ov || out_ch.ready;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_MXZ: begin ma = 33'(sx); mb = 33'(sz); end
      S_MXX: begin ma = 33'(sx); mb = 33'(sx); end
      S_MQY: begin ma = 33'(qv); mb = 33'(sy); end
      S_MHF: begin ma = 33'(h);  mb = 33'(fv); end
      S_MHZ: begin ma = 33'(h);  mb = 33'(sz); end
      S_SMUL: begin ma = 33'(f2); mb = 33'(nu2) - 33'(nu1); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // secant divider operands
  assign dv_start = (state == S_SDIV) && (ph == 2'd0);
  assign dv_num   = sprod;
  assign dv_den   = 34'(f2) - 34'(f1);

  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = ov;
  assign out_ch.position       = opos;
  assign out_ch.solution_value = oval;
  assign out_ch.converged      = oconv;
  assign out_ch.last_point     = olast;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      step_size      <= 31'd3355443;
      step_count     <= 6'd10;
      tolerance      <= 31'd16777;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_START_POSITION: start_position <= cfg_data;
        CFG_STEP_SIZE:      step_size      <= cfg_data[30:0];
        CFG_STEP_COUNT:     step_count     <= cfg_data[5:0];
        CFG_TOLERANCE:      tolerance      <= cfg_data[30:0];
        default:            step_count     <= step_count;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      ph    <= 2'd0;
    end else begin
      // S_EMIT reloads the output register itself
      if (ov && out_ch.ready && state != S_EMIT) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            y0    <= in_ch.start_value;
            yt    <= in_ch.end_value;
            nu1   <= Q_ONE;
            nu2   <= Q_SLOPE2;
            iter  <= '0;
            conv  <= 1'b0;
            rk    <= R_F1;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          x     <= start_position;
          y     <= y0;
          z     <= (rk == R_F1) ? nu1 : nu2;
          xacc  <= '0;
          idx   <= '0;
          state <= (rk == R_FINAL) ? S_EMIT : S_RUN;
        end
        S_RUN: state <= (idx == n_steps) ? S_END : S_STEP;
        S_EMIT: begin
          if (o_free) begin
            ov    <= 1'b1;
            opos  <= x;
            oval  <= y;
            oconv <= conv;
            olast <= (idx == n_steps);
            state <= S_RUN;
          end
        end
        S_STEP: begin
          xm     <= sat32(48'(x) + 48'(h >>> 1));
          xe     <= sat32(48'(x) + 48'(h));
          sx     <= x;
          sy     <= y;
          sz     <= z;
          ksum   <= '0;
          lsum   <= '0;
          sg     <= 2'd0;
          ph     <= 2'd0;
          d6_cnt <= '0;
          state  <= S_MXZ;
        end
        // one product per state, taken once the phase counter ph reaches 2
        S_MXZ, S_MXX, S_MQY, S_MHF, S_MHZ, S_SMUL: begin
          if (ph != 2'd2) begin
            ph <= ph + 2'd1;
          end else begin
            ph <= 2'd0;
            unique case (state)
              S_MXZ: begin tv <= sat32(48'(mr) <<< 2); state <= S_MXX; end
              S_MXX: begin
                qv    <= sat32((48'(mr) <<< 2) + 48'(Q_TWO));
                state <= S_MQY;
              end
              S_MQY: begin fv <= sat32(-48'(tv) - 48'(mr)); state <= S_MHF; end
              S_MHF: begin
                fv    <= mr;
                lsum  <= lsum + (w2 ? (36'(mr) <<< 1) : 36'(mr));
                state <= S_MHZ;
              end
              S_MHZ: begin
                tv    <= mr;
                ksum  <= ksum + (w2 ? (36'(mr) <<< 1) : 36'(mr));
                state <= S_NEXT;
              end
              default: begin sprod <= mp; state <= S_SDIV; end
            endcase
          end
        end
        // arguments of the next stage (fv holds l, tv holds k)
        S_NEXT: begin
          if (sg == 2'd3) begin
            state <= S_DIVK;
          end else begin
            if (sg == 2'd2) begin
              sx <= xe;
              sy <= sat32(48'(y) + 48'(tv));
              sz <= sat32(48'(z) + 48'(fv));
            end else begin
              sx <= xm;
              sy <= sat32(48'(y) + 48'(half32(tv)));
              sz <= sat32(48'(z) + 48'(half32(fv)));
            end
            sg    <= sg + 2'd1;
            state <= S_MXZ;
          end
        end
        // weighted sums over 6, one add per cycle, truncated toward zero
        S_DIVK, S_DIVL: begin
          if (d6_cnt == 4'd8) begin
            d6_cnt <= '0;
            if (state == S_DIVK) begin
              y     <= sat32(48'(y) + 48'(q6));
              state <= S_DIVL;
            end else begin
              z     <= sat32(48'(z) + 48'(q6));
              state <= S_ADV;
            end
          end else begin
            d6_cnt <= d6_cnt + 4'd1;
            case (d6_cnt)
              4'd0: begin
                d6_m   <= d6_abs[34:1];
                d6_neg <= d6_sum[35];
              end
              4'd1: d6_q <= (d6_m >> 2) + (d6_m >> 4);
              4'd2: d6_q <= d6_q + (d6_q >> 4);
              4'd3: d6_q <= d6_q + (d6_q >> 8);
              4'd4: d6_q <= d6_q + (d6_q >> 16);
              4'd5: d6_q <= d6_q + (d6_q >> 32);
              // estimate is low by a few units; remainder stays below 32
              4'd6: d6_r <= 36'(d6_m) - 36'(d6_q) - (36'(d6_q) << 1);
              4'd7: d6_q <= d6_q + 34'(((d6_r << 3) + (d6_r << 1) + d6_r) >> 5);
              default: ;
            endcase
          end
        end
        S_ADV: begin
          idx   <= idx + 1'b1;
          xacc  <= xacc + 38'(h);
          x     <= sat32(48'(start_position) + 48'(xacc) + 48'(h));
          state <= (rk == R_FINAL) ? S_EMIT : S_RUN;
        end
        S_END: begin
          unique case (rk)
            R_F1: begin
              f1    <= sat32(48'(y) - 48'(yt));
              rk    <= R_F2;
              state <= S_INIT;
            end
            R_F2, R_ITER: begin
              f2    <= sat32(48'(y) - 48'(yt));
              state <= S_CHECK;
            end
            default: state <= S_IDLE;
          endcase
        end
        // secant decision
        S_CHECK: begin
          if (f2mag <= {2'b0, tolerance}) begin
            conv  <= 1'b1;
            rk    <= R_FINAL;
            state <= S_INIT;
          end else if (iter >= ITER_W'(MAX_ITERATIONS) || f2 == f1) begin
            rk    <= R_FINAL;
            state <= S_INIT;
          end else begin
            ph    <= 2'd0;
            state <= S_SMUL;
          end
        end
        S_SDIV: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (dv_done) begin
            nu1   <= nu2;
            nu2   <= sat32(48'(nu2) - 48'(corr));
            f1    <= f2;
            iter  <= iter + 1'b1;
            rk    <= R_ITER;
            ph    <= 2'd0;
            state <= S_INIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    dv_start |-> !dv_busy)
    else $error("divider started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && ov && !out_ch.ready |=> $stable(opos) && $stable(oval))
    else $error("pending output word overwritten");

endmodule

// ===== rtl/rk4sb_mul.sv =====
`timescale 1ns / 1ps
module rk4sb_mul import rk4sb_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [63:0] p,
  output q_t                 r
);

  localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);

  logic signed [65:0] prod;
  logic signed [64:0] rnd;
  logic signed [64:0] shr;

  assign prod = a * b;
  // round to nearest, ties up, then saturate
  assign rnd = 65'(p) + RND;
  assign shr = rnd >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    p <= prod[63:0];
    r <= sat32(shr[47:0]);
  end

endmodule

// ===== rtl/rk4sb_div.sv =====
`timescale 1ns / 1ps
module rk4sb_div import rk4sb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [33:0] den,
  output logic               busy,
  output logic               done,
  output logic [63:0]        qmag,
  output logic               qneg
);

  logic [63:0] nmag;
  logic [33:0] dmag_in;
  logic [33:0] dmag;
  logic [63:0] dvd;
  logic [34:0] rem;
  logic [34:0] rem_sh;
  logic        fits;
  logic [6:0]  cnt;

  assign nmag    = num[63] ? (~num + 64'd1) : num;
  assign dmag_in = den[33] ? (~den + 34'd1) : den;
  assign rem_sh  = {rem[33:0], dvd[63]};
  assign fits    = rem_sh >= {1'b0, dmag};

  // restoring divide on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        dvd  <= nmag;
        dmag <= dmag_in;
        rem  <= '0;
        qmag <= '0;
        qneg <= num[63] ^ den[33];
      end else if (busy) begin
        dvd  <= {dvd[62:0], 1'b0};
        rem  <= fits ? (rem_sh - {1'b0, dmag}) : rem_sh;
        qmag <= {qmag[62:0], fits};
        cnt  <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== bench/rk4sb_solution_checker.sv =====
`timescale 1ns / 1ps
module rk4sb_solution_checker import rk4sb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rk4sb_in_if         in_ch,
  rk4sb_out_if        out_ch,
  output int          fail_count,
  output int          points_waiting,
  output int          points_seen
);

  typedef struct {
    logic signed [31:0] position;
    logic signed [31:0] solution_value;
    logic               converged;
    logic               last_point;
  } grid_point_t;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam longint CLAMP = longint'(1) << 40;

  grid_point_t grid_q[$];

  // register mirror
  longint x_left;
  longint h_step;
  int     n_steps;
  longint tol;

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product rounded to nearest, ties up, then saturated
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clip((p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  // z' = -4x*z - (4x^2+2)*y
  function automatic longint accel(longint x, longint y, longint z);
    longint t, q;
    t = clip(4 * qmul(x, z));
    q = clip(4 * qmul(x, x) + 2 * ONE_Q);
    return clip(-t - qmul(q, y));
  endfunction

  // one RK4 pass from the left end; returns y at the right end
  function automatic longint rk4_pass(longint y0, longint z0,
                                      output longint xs[64], output longint ys[64]);
    longint x, y, z, xm, xe, k1, k2, k3, k4, l1, l2, l3, l4, zm, ze;
    int n;
    n = (n_steps > MAX_POINTS - 1) ? MAX_POINTS - 1 : n_steps;
    y = y0;
    z = z0;
    x = clip(x_left);
    xs[0] = x;
    ys[0] = y;
    for (int i = 1; i <= n; i++) begin
      xm = clip(x + h_step / 2);
      xe = clip(x + h_step);
      k1 = qmul(h_step, z);
      l1 = qmul(h_step, accel(x, y, z));
      zm = clip(z + l1 / 2);
      k2 = qmul(h_step, zm);
      l2 = qmul(h_step, accel(xm, clip(y + k1 / 2), zm));
      zm = clip(z + l2 / 2);
      k3 = qmul(h_step, zm);
      l3 = qmul(h_step, accel(xm, clip(y + k2 / 2), zm));
      ze = clip(z + l3);
      k4 = qmul(h_step, ze);
      l4 = qmul(h_step, accel(xe, clip(y + k3), ze));
      y = clip(y + (k1 + 2 * k2 + 2 * k3 + k4) / 6);
      z = clip(z + (l1 + 2 * l2 + 2 * l3 + l4) / 6);
      x = clip(x_left + longint'(i) * h_step);
      xs[i] = x;
      ys[i] = y;
    end
    return y;
  endfunction

  // secant shooting search, then queue every grid point of the final pass
  function automatic void shoot(longint y0, longint y1);
    longint s1, s2, e1, e2, den, corr, nn, mag;
    longint xs[64], ys[64];
    grid_point_t g;
    int it, n;
    bit ok;
    s1 = ONE_Q;
    s2 = ((longint'(8) << FRAC_BITS) + 5) / 10;
    e1 = clip(rk4_pass(y0, s1, xs, ys) - y1);
    e2 = clip(rk4_pass(y0, s2, xs, ys) - y1);
    ok = 0;
    it = 0;
    forever begin
      mag = (e2 < 0) ? -e2 : e2;
      if (mag <= tol) begin
        ok = 1;
        break;
      end
      if (it >= MAX_ITERATIONS) break;
      den = e2 - e1;
      if (den == 0) break;
      corr = (e2 * (s2 - s1)) / den;
      if (corr > CLAMP) corr = CLAMP;
      if (corr < -CLAMP) corr = -CLAMP;
      nn = clip(s2 - corr);
      s1 = s2;
      s2 = nn;
      e1 = e2;
      e2 = clip(rk4_pass(y0, s2, xs, ys) - y1);
      it++;
    end
    void'(rk4_pass(y0, s2, xs, ys));
    n = (n_steps > MAX_POINTS - 1) ? MAX_POINTS - 1 : n_steps;
    for (int i = 0; i <= n; i++) begin
      g.position       = xs[i][31:0];
      g.solution_value = ys[i][31:0];
      g.converged      = ok;
      g.last_point     = (i == n);
      grid_q.insert(grid_q.size(), g);
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // track config, predict on accepted input words, check output words
  always @(posedge clk) begin
    grid_point_t w;
    if (rst) begin
      x_left  = 0;
      h_step  = 3355443;
      n_steps = 10;
      tol     = 16777;
      grid_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_POSITION: x_left  = longint'($signed(cfg_data));
          CFG_STEP_SIZE:      h_step  = longint'(cfg_data[30:0]);
          CFG_STEP_COUNT:     n_steps = int'(cfg_data[5:0]);
          CFG_TOLERANCE:      tol     = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        shoot(longint'(in_ch.start_value), longint'(in_ch.end_value));
      if (out_ch.valid && out_ch.ready) begin
        points_seen++;
        if (grid_q.size() == 0) begin
          report("unexpected word, position", out_ch.position, 0);
        end else begin
          w = grid_q.pop_front();
          if (out_ch.position !== w.position)
            report("position", out_ch.position, w.position);
          if (out_ch.solution_value !== w.solution_value)
            report("solution_value", out_ch.solution_value, w.solution_value);
          if (out_ch.converged !== w.converged)
            report("converged", out_ch.converged, w.converged);
          if (out_ch.last_point !== w.last_point)
            report("last_point", out_ch.last_point, w.last_point);
        end
      end
    end
    points_waiting = grid_q.size();
  end

endmodule

// ===== bench/tb_rk4_shooting_boundary_solver.sv =====
`timescale 1ns / 1ps
module tb_rk4_shooting_boundary_solver;
  import rk4sb_pkg::*;

  localparam int     CYCLE_LIMIT = 6000000;
  localparam longint ONE_Q       = longint'(1) << FRAC_BITS;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          points_waiting;
  int          points_seen;
  int          words_sent;
  int          cycles;
  int          burst_left;
  int          stall_mode;
  int          stall_left;

  rk4sb_in_if  in_ch();
  rk4sb_out_if out_ch();

  rk4_shooting_boundary_solver i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rk4sb_solution_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .points_waiting (points_waiting),
    .points_seen    (points_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls: modes of always ready, light and heavy stalling
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all four registers, block idle
  task automatic set_regs(logic [31:0] xl, logic [31:0] h, logic [31:0] n, logic [31:0] tl);
    write_reg(CFG_START_POSITION, xl);
    write_reg(CFG_STEP_SIZE, h);
    write_reg(CFG_STEP_COUNT, n);
    write_reg(CFG_TOLERANCE, tl);
  endtask

  // bursts of words with random gaps; valid stays up inside a burst
  task automatic send_word(logic [31:0] y0, logic [31:0] y1);
    int gap;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.start_value <= y0;
    in_ch.end_value   <= y1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // wait for all points out and the block idle before touching registers
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (points_waiting != 0 || !in_ch.ready) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic [31:0] h;
    rst               = 1;
    cfg_we            = 0;
    cfg_index         = CFG_START_POSITION;
    cfg_data          = 0;
    in_ch.valid       = 0;
    in_ch.start_value = 0;
    in_ch.end_value   = 0;
    words_sent        = 0;
    burst_left        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset defaults: field extremes and plain targets
    send_word(32'h0, 32'h0);
    send_word(32'(ONE_Q), 32'h0);
    send_word(32'h7fffffff, 32'h80000000);
    send_word(32'h80000000, 32'h7fffffff);
    send_word(32'h0, 32'(ONE_Q));
    send_word(32'(-ONE_Q), 32'(ONE_Q));
    send_word(32'hffffffff, 32'h00000001);
    drain();

    // saturating grid, zero tolerance: iteration cap and flat secant
    set_regs(32'h80000000, 32'h7fffffff, 32'd2, 32'd0);
    send_word(32'h7fffffff, 32'h7fffffff);
    send_word(32'h80000000, 32'h0);
    send_word(32'(ONE_Q), 32'h80000000);
    send_word(32'h0, 32'h12345678);
    drain();

    // zero steps, zero step size, widest tolerance
    set_regs(32'h7fffffff, 32'd0, 32'd0, 32'h7fffffff);
    send_word(32'h0, 32'h7fffffff);
    send_word(32'h80000000, 32'h80000000);
    drain();
    set_regs(32'h0, 32'd0, 32'd3, 32'd0);
    send_word(32'(ONE_Q), 32'(2 * ONE_Q));
    send_word(32'h0, 32'h0);
    drain();

    // longest grid and counts above the point limit
    set_regs(32'hff000000, 32'd1 << 18, 32'd63, 32'd1000);
    send_word(32'(ONE_Q / 2), 32'(ONE_Q / 4));
    drain();
    set_regs(32'h0, 32'd1 << 20, 32'hffffffff, 32'h7fffffff);
    send_word(32'(ONE_Q), 32'h0);
    drain();

    // random phases, all with short grids
    for (int ph = 0; ph < 7; ph++) begin
      h = (ph == 6) ? $urandom : $urandom_range(0, 32'h0080_0000);
      set_regs($urandom, h, $urandom_range(1, 5),
               ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000));
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(0, 2) == 0)
          send_word($urandom, $urandom);
        else
          send_word($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000,
                    $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("sent %0d input words, checked %0d grid points", words_sent, points_seen);
    $display("covered default, saturating, zero-step, long-grid and random register sets");
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
